// ===== hw/rtl/flr_pkg.sv =====
`timescale 1ns / 1ps

package flr_pkg;

    // Line buffer size in bytes; headers announcing longer lines are refused
    localparam int unsigned LINE_BUFFER_BYTES = 4096;
    localparam int unsigned LEN_W             = 13;
    localparam int unsigned ADDR_W            = 12;
    localparam int unsigned SEQ_W             = 16;
    localparam logic [SEQ_W-1:0] SEQ_LIMIT    = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_CAP       = 2'd0,
        CFG_FRAGMENT_TYPE  = 2'd1,
        CFG_LAST_FLAG_MASK = 2'd2
    } cfg_index_t;

    localparam logic [LEN_W-1:0] LINE_CAP_RESET       = 13'd4096;
    localparam logic [7:0]       FRAGMENT_TYPE_RESET  = 8'd1;
    localparam logic [7:0]       LAST_FLAG_MASK_RESET = 8'd1;

    // Item operation codes
    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_BYTE   = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_HEADER_OK        = 4'd0,
        ST_BYTE_STORED      = 4'd1,
        ST_IN_PROGRESS      = 4'd2,
        ST_COMPLETE         = 4'd3,
        ST_BAD_FRAME        = 4'd4,
        ST_TOO_LARGE        = 4'd5,
        ST_SEQUENCE         = 4'd6,
        ST_TOTAL_MISMATCH   = 4'd7,
        ST_PAYLOAD_MISMATCH = 4'd8,
        ST_STRAY            = 4'd9
    } status_t;

    typedef struct packed {
        logic             operation;
        logic [7:0]       frame_type;
        logic [7:0]       flags_byte;
        logic [SEQ_W-1:0] sequence_number;
        logic [31:0]      total_length;
        logic [15:0]      payload_length;
        logic [7:0]       payload_byte;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [LEN_W-1:0]  line_size;
    } out_item_t;

endpackage

// ===== hw/rtl/fragment_line_reassembler.sv =====
`timescale 1ns / 1ps

// Fragment line reassembler.
// Input channel s_valid/s_ready/s_item carries header items (operation 0) and
// payload byte items (operation 1). Each accepted item yields exactly one
// result item on m_valid/m_ready/m_item: a status, an optional line-buffer
// write (write_enable, write_address, write_data) and the line size when a
// line completes. The caller applies the writes to its own line buffer.
// The result of an accepted item is registered in the result register, or in
// the skid register while a result waits. One item is accepted per cycle while
// s_ready is high; the header checks and the counter updates are combinational
// between the input and the result register. A one-entry skid register behind
// the result register lets one more item in while a result waits; s_ready
// drops only when both hold a result. Configuration (cfg_write_enable,
// cfg_index, cfg_write_data) must be written only while no item is in flight;
// the block does not enforce it. Reset (aresetn low, synchronous) drops any
// open line, empties both result registers and restores the register defaults.
module fragment_line_reassembler
    import flr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_item,
    input  logic              cfg_write_enable,
    input  logic [1:0]        cfg_index,
    input  logic [LEN_W-1:0]  cfg_write_data
);

    // Configuration registers
    logic [LEN_W-1:0] line_cap_reg;
    logic [7:0]       fragment_type_code_reg;
    logic [7:0]       last_flag_mask_reg;

    // Line state
    logic             line_active_reg,       line_active_next;
    logic [LEN_W-1:0] expected_total_reg,    expected_total_next;
    logic [LEN_W-1:0] bytes_received_reg,    bytes_received_next;
    logic [SEQ_W-1:0] expected_sequence_reg, expected_sequence_next;
    logic [15:0]      bytes_pending_reg,     bytes_pending_next;
    status_t          final_status_reg,      final_status_next;
    logic [LEN_W-1:0] final_line_size_reg,   final_line_size_next;

    // Result and skid registers
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      skid_valid_reg;
    out_item_t skid_item_reg;

    logic      accept;
    out_item_t result;

    // Header helpers
    logic             last_flag;
    logic             bad_frame;
    logic             too_large;
    logic [LEN_W-1:0] eff_total;
    logic [LEN_W-1:0] eff_received;
    logic [SEQ_W-1:0] eff_sequence;
    logic [LEN_W-1:0] room;
    logic [LEN_W+3:0] filled;
    status_t          outcome;
    logic [LEN_W-1:0] outcome_size;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Write configuration; indexes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_cap_reg           <= LINE_CAP_RESET;
            fragment_type_code_reg <= FRAGMENT_TYPE_RESET;
            last_flag_mask_reg     <= LAST_FLAG_MASK_RESET;
        end else if (cfg_write_enable) begin
            case (cfg_index)
                CFG_LINE_CAP:       line_cap_reg           <= cfg_write_data;
                CFG_FRAGMENT_TYPE:  fragment_type_code_reg <= cfg_write_data[7:0];
                CFG_LAST_FLAG_MASK: last_flag_mask_reg     <= cfg_write_data[7:0];
                default: ;
            endcase
        end
    end

    // Header check terms
    always_comb begin
        last_flag = |(s_item.flags_byte & last_flag_mask_reg);
        bad_frame = (s_item.frame_type != fragment_type_code_reg)
                    || (|(s_item.flags_byte & ~last_flag_mask_reg))
                    || (s_item.total_length == 32'd0)
                    || ({16'd0, s_item.payload_length} > s_item.total_length);
        too_large = (s_item.total_length > {{(32-LEN_W){1'b0}}, line_cap_reg})
                    || (s_item.total_length > 32'(LINE_BUFFER_BYTES));
        if (line_active_reg) begin
            eff_total    = expected_total_reg;
            eff_received = bytes_received_reg;
            eff_sequence = expected_sequence_reg;
        end else begin
            eff_total    = s_item.total_length[LEN_W-1:0];
            eff_received = '0;
            eff_sequence = '0;
        end
        room   = eff_total - eff_received;
        filled = {4'd0, eff_received} + {1'b0, s_item.payload_length};
        if (!last_flag) begin
            outcome      = ST_IN_PROGRESS;
            outcome_size = '0;
        end else if (filled != {4'd0, eff_total}) begin
            outcome      = ST_PAYLOAD_MISMATCH;
            outcome_size = '0;
        end else begin
            outcome      = ST_COMPLETE;
            outcome_size = eff_total;
        end
    end

    // Process one item: build its result and the next line state
    always_comb begin
        line_active_next       = line_active_reg;
        expected_total_next    = expected_total_reg;
        bytes_received_next    = bytes_received_reg;
        expected_sequence_next = expected_sequence_reg;
        bytes_pending_next     = bytes_pending_reg;
        final_status_next      = final_status_reg;
        final_line_size_next   = final_line_size_reg;
        result                 = '{status: ST_HEADER_OK, write_enable: 1'b0,
                                   write_address: '0, write_data: '0, line_size: '0};

        if (s_item.operation == OP_HEADER) begin
            // Any failure drops the line: every state field returns to zero
            line_active_next       = 1'b0;
            expected_total_next    = '0;
            bytes_received_next    = '0;
            expected_sequence_next = '0;
            bytes_pending_next     = '0;
            final_status_next      = ST_HEADER_OK;
            final_line_size_next   = '0;
            if (bytes_pending_reg != 16'd0) begin
                result.status = ST_PAYLOAD_MISMATCH;
            end else if (bad_frame) begin
                result.status = ST_BAD_FRAME;
            end else if (too_large) begin
                result.status = ST_TOO_LARGE;
            end else if (!line_active_reg && s_item.sequence_number != '0) begin
                result.status = ST_SEQUENCE;
            end else if (line_active_reg
                         && s_item.total_length != {{(32-LEN_W){1'b0}}, expected_total_reg}) begin
                result.status = ST_TOTAL_MISMATCH;
            end else if (s_item.sequence_number != eff_sequence) begin
                result.status = ST_SEQUENCE;
            end else if (s_item.payload_length > {3'd0, room}) begin
                result.status = ST_PAYLOAD_MISMATCH;
            end else if (eff_sequence == SEQ_LIMIT
                         && (filled < {4'd0, eff_total} || !last_flag)) begin
                result.status = ST_SEQUENCE;
            end else if (s_item.payload_length == 16'd0) begin
                // Empty fragment reports its outcome at once
                result.status    = outcome;
                result.line_size = outcome_size;
                if (outcome == ST_IN_PROGRESS) begin
                    line_active_next       = 1'b1;
                    expected_total_next    = eff_total;
                    bytes_received_next    = eff_received;
                    expected_sequence_next = eff_sequence + 1'b1;
                end
            end else begin
                // Hold the outcome until the fragment's last byte
                result.status          = ST_HEADER_OK;
                line_active_next       = 1'b1;
                expected_total_next    = eff_total;
                bytes_received_next    = eff_received;
                expected_sequence_next = eff_sequence + 1'b1;
                bytes_pending_next     = s_item.payload_length;
                final_status_next      = outcome;
                final_line_size_next   = outcome_size;
            end
        end else if (bytes_pending_reg == 16'd0) begin
            result.status = ST_STRAY;
        end else begin
            result.write_enable  = 1'b1;
            result.write_address = bytes_received_reg[ADDR_W-1:0];
            result.write_data    = s_item.payload_byte;
            bytes_received_next  = bytes_received_reg + 1'b1;
            bytes_pending_next   = bytes_pending_reg - 1'b1;
            if (bytes_pending_reg == 16'd1) begin
                // Last byte of the fragment carries the settled outcome
                result.status        = final_status_reg;
                result.line_size     = (final_status_reg == ST_COMPLETE)
                                       ? final_line_size_reg : '0;
                final_status_next    = ST_HEADER_OK;
                final_line_size_next = '0;
                if (final_status_reg == ST_COMPLETE
                    || final_status_reg == ST_PAYLOAD_MISMATCH) begin
                    line_active_next       = 1'b0;
                    expected_total_next    = '0;
                    bytes_received_next    = '0;
                    expected_sequence_next = '0;
                end
            end else begin
                result.status = ST_BYTE_STORED;
            end
        end
    end

    // Advance line state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg       <= 1'b0;
            expected_total_reg    <= '0;
            bytes_received_reg    <= '0;
            expected_sequence_reg <= '0;
            bytes_pending_reg     <= '0;
            final_status_reg      <= ST_HEADER_OK;
            final_line_size_reg   <= '0;
        end else if (accept) begin
            line_active_reg       <= line_active_next;
            expected_total_reg    <= expected_total_next;
            bytes_received_reg    <= bytes_received_next;
            expected_sequence_reg <= expected_sequence_next;
            bytes_pending_reg     <= bytes_pending_next;
            final_status_reg      <= final_status_next;
            final_line_size_reg   <= final_line_size_next;
        end
    end

    // Result register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : result;
        end else if (accept) begin
            skid_item_reg <= result;
        end
    end

    // Skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    // Writes only come with byte outcomes
    a_write_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.write_enable) |->
            (m_item.status == ST_BYTE_STORED || m_item.status == ST_IN_PROGRESS
             || m_item.status == ST_COMPLETE || m_item.status == ST_PAYLOAD_MISMATCH))
        else $error("buffer write reported with a non-byte status");

    // Line size only reported on completion
    a_size_on_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.line_size != '0) |-> (m_item.status == ST_COMPLETE))
        else $error("line size reported without completion");

    // Pending bytes belong to an open line that has room for them
    a_pending_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_pending_reg != 16'd0) |->
            (line_active_reg && bytes_received_reg < expected_total_reg))
        else $error("bytes pending outside an open line");

    a_received_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_received_reg <= expected_total_reg)
        else $error("received count exceeds the line total");

endmodule
